@@ hw/rtl/pclc_pkg.sv @@
// Shared types, widths and codes for the padded circular line convolution block.
`timescale 1ns / 1ps

package pclc_pkg;

    localparam int LINE_MAX_DEFAULT = 64;

    localparam int ACTION_W   = 1;
    localparam int TAP_IDX_W  = 6;
    localparam int TAP_W      = 17;
    localparam int SAMPLE_W   = 32;
    localparam int LEN_W      = 7;
    localparam int PLOG_W     = 3;
    localparam int POW_W      = 2 ** PLOG_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEN_W;

    // Ramp difference of two Q16.16 samples.
    localparam int DIVIDEND_W = SAMPLE_W + 1;

    // Signed sample times zero-extended tap.
    localparam int PROD_W     = SAMPLE_W + TAP_W + 1;
    localparam int FRAC_W     = 16;
    localparam int ROUND_BIAS = 2 ** (FRAC_W - 1);

    localparam logic [LEN_W-1:0]  LINE_LENGTH_RST = LEN_W'(64);
    localparam logic [PLOG_W-1:0] PLOG_RST        = PLOG_W'(6);

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_LOG2 = CFG_IDX_W'(1);

    localparam logic [ACTION_W-1:0] ACTION_TAP    = 1'b0;
    localparam logic [ACTION_W-1:0] ACTION_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_FIRST,
        ST_READ_LAST,
        ST_START_DIV,
        ST_DIVIDE,
        ST_PAD,
        ST_MAC,
        ST_WAIT_MAC,
        ST_OUTPUT
    } state_t;

    // Travels with the registered memory read data into the MAC.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

endpackage

@@ hw/rtl/pclc_if.sv @@
// Valid/ready stream interfaces for input items and filtered results.
`timescale 1ns / 1ps

interface pclc_item_if;
    logic                                valid;
    logic                                ready;
    logic [pclc_pkg::ACTION_W-1:0]       action;
    logic [pclc_pkg::TAP_IDX_W-1:0]      tap_index;
    logic [pclc_pkg::TAP_W-1:0]          tap_value;
    logic signed [pclc_pkg::SAMPLE_W-1:0] sample_value;

    modport source (
        output valid,
        output action,
        output tap_index,
        output tap_value,
        output sample_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  tap_index,
        input  tap_value,
        input  sample_value,
        output ready
    );
endinterface

interface pclc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pclc_pkg::SAMPLE_W-1:0] filtered_value;
    logic                                last_of_line;

    modport source (
        output valid,
        output filtered_value,
        output last_of_line,
        input  ready
    );

    modport sink (
        input  valid,
        input  filtered_value,
        input  last_of_line,
        output ready
    );
endinterface

@@ hw/rtl/pclc_div.sv @@
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module pclc_div #(
    parameter int DIV_W = 7
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [pclc_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [DIV_W-1:0]                       divisor,
    output logic                                   done,
    output logic signed [pclc_pkg::DIVIDEND_W-1:0] quotient
);

    localparam int NUM_W = pclc_pkg::DIVIDEND_W;
    localparam int CNT_BITS = $clog2(NUM_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    den_reg;
    logic                neg_reg;

    logic [DIV_W:0]      shifted;
    logic [DIV_W:0]      diff;
    logic                fits;
    logic [DIV_W-1:0]    rem_next;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = (shifted >= {1'b0, den_reg});
        rem_next = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_BITS'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Work on the magnitude; the divisor is always positive.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
            neg_reg <= dividend[NUM_W-1];
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

@@ hw/rtl/pclc_mac.sv @@
// Shared multiply-accumulate unit with Q16.16 rounding and saturation.
`timescale 1ns / 1ps

module pclc_mac #(
    parameter int LINE_MAX = pclc_pkg::LINE_MAX_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pclc_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [pclc_pkg::SAMPLE_W-1:0] x,
    input  logic [pclc_pkg::TAP_W-1:0]           h,
    output logic                                 done,
    output logic signed [pclc_pkg::SAMPLE_W-1:0] result
);

    localparam int PROD_W = pclc_pkg::PROD_W;
    localparam int ACC_W  = PROD_W + $clog2(LINE_MAX);
    localparam int SW     = pclc_pkg::SAMPLE_W;
    localparam int QW     = ACC_W + 1 - pclc_pkg::FRAC_W;
    localparam logic signed [ACC_W:0] ROUND_ADD = (ACC_W + 1)'(pclc_pkg::ROUND_BIAS);

    pclc_pkg::mac_ctrl_t      prod_ctrl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic signed [SW-1:0]     res_reg;

    logic signed [ACC_W:0]    rnd;
    logic [QW-1:0]            quot;
    logic [QW-SW:0]           high_bits;
    logic signed [SW-1:0]     sat;

    // Add half an LSB, floor by the shift, clamp when the high bits disagree.
    always_comb
    begin
        rnd       = (ACC_W + 1)'(acc_reg) + ROUND_ADD;
        quot      = rnd[ACC_W:pclc_pkg::FRAC_W];
        high_bits = quot[QW-1:SW-1];
        if ((&high_bits) || !(|high_bits))
        begin
            sat = quot[SW-1:0];
        end
        else if (quot[QW-1])
        begin
            sat = {1'b1, {(SW - 1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(SW - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctrl_reg <= '0;
            fin_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            prod_ctrl_reg <= ctrl;
            fin_reg       <= prod_ctrl_reg.valid && prod_ctrl_reg.last;
            done_reg      <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= x * $signed({1'b0, h});
        if (prod_ctrl_reg.valid)
        begin
            acc_reg <= (prod_ctrl_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
        end
        if (fin_reg)
        begin
            res_reg <= sat;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ hw/rtl/padded_circular_line_convolution.sv @@
// Top level: tap and line stores, sequencer, ramp divider and shared MAC.
`timescale 1ns / 1ps

// Channel  | Dir | Payload                                         | Transfer
// item     | in  | action, tap_index, tap_value, sample_value      | valid & ready
// result   | out | filtered_value, last_of_line                    | valid & ready
// cfg      | in  | cfg_addr, cfg_wdata (line_length, padded log2)  | cfg_wen
//
// A tap load or a sample that does not end the line is written while the block stays idle.
// A line of L > 1 samples padded to P reads first and last samples; when L < P,
// the bit-serial divider finds the ramp step and P - L pad writes follow, then per
// result P tap reads go through the single MAC, then drain, rounding and handoff.
// Reset clears the sequencer and sample count and presets the config, not the stores.
// The block takes no item while a line is in progress; a stalled result holds.

module padded_circular_line_convolution #(
    parameter int LINE_MAX = pclc_pkg::LINE_MAX_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    pclc_item_if.sink                          item,
    pclc_result_if.source                      result,
    input  logic                               cfg_wen,
    input  logic [pclc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pclc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int ADDR_W = $clog2(LINE_MAX);
    localparam int CNT_W  = $clog2(LINE_MAX + 1);
    localparam int SW     = pclc_pkg::SAMPLE_W;

    // Stores
    logic signed [SW-1:0]           line_mem [LINE_MAX];
    logic [pclc_pkg::TAP_W-1:0]     kern_mem [LINE_MAX];
    logic signed [SW-1:0]           line_rdata_reg;
    logic [pclc_pkg::TAP_W-1:0]     kern_rdata_reg;

    // Control state
    pclc_pkg::state_t               state_reg, state_next;
    logic [ADDR_W-1:0]              sample_count_reg, sample_count_next;
    logic [pclc_pkg::LEN_W-1:0]     line_length_reg;
    logic [pclc_pkg::PLOG_W-1:0]    plog_reg;
    pclc_pkg::mac_ctrl_t            rd_ctrl_reg, rd_ctrl_next;

    // Line working registers
    logic [CNT_W-1:0]               len_reg, len_next;
    logic [CNT_W-1:0]               p_reg, p_next;
    logic [ADDR_W-1:0]              i_reg, i_next;
    logic [ADDR_W-1:0]              j_reg, j_next;
    logic [ADDR_W-1:0]              t_reg, t_next;
    logic [ADDR_W-1:0]              k_reg, k_next;
    logic signed [SW-1:0]           first_reg, first_next;
    logic signed [SW-1:0]           pad_reg, pad_next;
    logic signed [SW-1:0]           out_value_reg, out_value_next;
    logic                           out_last_reg, out_last_next;

    // Combinational
    logic [CNT_W-1:0]               len_eff;
    logic [CNT_W-1:0]               p_eff;
    logic [pclc_pkg::POW_W-1:0]     pow;
    logic [CNT_W-1:0]               cnt1;
    logic signed [SW-1:0]           pad_sum;
    logic                           last_tap;
    logic                           item_ready;
    logic                           res_valid;
    logic                           line_we;
    logic [ADDR_W-1:0]              line_waddr;
    logic signed [SW-1:0]           line_wdata;
    logic [ADDR_W-1:0]              line_raddr;
    logic [ADDR_W-1:0]              kern_raddr;
    logic                           kern_we;
    logic                           div_start;
    logic                           div_done;
    logic signed [pclc_pkg::DIVIDEND_W-1:0] div_dividend;
    logic signed [pclc_pkg::DIVIDEND_W-1:0] div_quot;
    logic [CNT_W-1:0]               div_divisor;
    logic                           mac_done;
    logic signed [SW-1:0]           mac_result;

    // Effective line length and padded length from the registers
    always_comb
    begin
        if (line_length_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (32'(line_length_reg) > LINE_MAX)
        begin
            len_eff = CNT_W'(LINE_MAX);
        end
        else
        begin
            len_eff = CNT_W'(line_length_reg);
        end

        pow = pclc_pkg::POW_W'(1) << plog_reg;
        if (32'(pow) > LINE_MAX)
        begin
            p_eff = CNT_W'(LINE_MAX);
        end
        else
        begin
            p_eff = CNT_W'(pow);
        end
        if (p_eff < len_eff)
        begin
            p_eff = len_eff;
        end
    end

    assign div_dividend = {first_reg[SW-1], first_reg} - {line_rdata_reg[SW-1], line_rdata_reg};
    assign div_divisor  = p_reg - len_reg + CNT_W'(1);
    assign pad_sum      = pad_reg + div_quot[SW-1:0];
    assign cnt1         = CNT_W'(sample_count_reg) + CNT_W'(1);
    assign last_tap     = (CNT_W'(j_reg) == p_reg - CNT_W'(1));

    always_comb
    begin
        state_next        = state_reg;
        sample_count_next = sample_count_reg;
        rd_ctrl_next      = '0;
        len_next          = len_reg;
        p_next            = p_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        t_next            = t_reg;
        k_next            = k_reg;
        first_next        = first_reg;
        pad_next          = pad_reg;
        out_value_next    = out_value_reg;
        out_last_next     = out_last_reg;
        item_ready        = 1'b0;
        res_valid         = 1'b0;
        line_we           = 1'b0;
        line_waddr        = k_reg;
        line_wdata        = pad_sum;
        line_raddr        = j_reg;
        kern_raddr        = t_reg;
        kern_we           = 1'b0;
        div_start         = 1'b0;

        unique case (state_reg)
            pclc_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item.valid)
                begin
                    if (item.action == pclc_pkg::ACTION_TAP)
                    begin
                        kern_we = (32'(item.tap_index) < LINE_MAX);
                    end
                    else
                    begin
                        line_we    = 1'b1;
                        line_waddr = sample_count_reg;
                        line_wdata = item.sample_value;
                        if (cnt1 >= len_eff)
                        begin
                            sample_count_next = '0;
                            len_next          = len_eff;
                            p_next            = p_eff;
                            state_next        = pclc_pkg::ST_READ_FIRST;
                        end
                        else
                        begin
                            sample_count_next = ADDR_W'(cnt1);
                        end
                    end
                end
            end

            pclc_pkg::ST_READ_FIRST:
            begin
                line_raddr = '0;
                state_next = pclc_pkg::ST_READ_LAST;
            end

            pclc_pkg::ST_READ_LAST:
            begin
                if (len_reg == CNT_W'(1))
                begin
                    // Single-sample line: pass the sample straight through.
                    out_value_next = line_rdata_reg;
                    out_last_next  = 1'b1;
                    state_next     = pclc_pkg::ST_OUTPUT;
                end
                else
                begin
                    first_next = line_rdata_reg;
                    line_raddr = ADDR_W'(len_reg - CNT_W'(1));
                    if (p_reg == len_reg)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        t_next     = '0;
                        state_next = pclc_pkg::ST_MAC;
                    end
                    else
                    begin
                        state_next = pclc_pkg::ST_START_DIV;
                    end
                end
            end

            pclc_pkg::ST_START_DIV:
            begin
                div_start  = 1'b1;
                pad_next   = line_rdata_reg;
                k_next     = ADDR_W'(len_reg);
                state_next = pclc_pkg::ST_DIVIDE;
            end

            pclc_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = pclc_pkg::ST_PAD;
                end
            end

            pclc_pkg::ST_PAD:
            begin
                // Ramp by repeated add of the step, one entry a cycle.
                line_we  = 1'b1;
                pad_next = pad_sum;
                k_next   = k_reg + ADDR_W'(1);
                if (CNT_W'(k_reg) == p_reg - CNT_W'(1))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    t_next     = '0;
                    state_next = pclc_pkg::ST_MAC;
                end
            end

            pclc_pkg::ST_MAC:
            begin
                rd_ctrl_next = '{valid: 1'b1, first: (j_reg == '0), last: last_tap};
                j_next       = j_reg + ADDR_W'(1);
                t_next       = (t_reg == '0) ? ADDR_W'(p_reg - CNT_W'(1)) : t_reg - ADDR_W'(1);
                if (last_tap)
                begin
                    state_next = pclc_pkg::ST_WAIT_MAC;
                end
            end

            pclc_pkg::ST_WAIT_MAC:
            begin
                if (mac_done)
                begin
                    out_value_next = mac_result;
                    out_last_next  = (CNT_W'(i_reg) == len_reg - CNT_W'(1));
                    state_next     = pclc_pkg::ST_OUTPUT;
                end
            end

            pclc_pkg::ST_OUTPUT:
            begin
                res_valid = 1'b1;
                if (result.ready)
                begin
                    if (out_last_reg)
                    begin
                        state_next = pclc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + ADDR_W'(1);
                        j_next     = '0;
                        t_next     = i_reg + ADDR_W'(1);
                        state_next = pclc_pkg::ST_MAC;
                    end
                end
            end

            default:
            begin
                state_next = pclc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pclc_pkg::ST_IDLE;
            sample_count_reg <= '0;
            rd_ctrl_reg      <= '0;
            line_length_reg  <= pclc_pkg::LINE_LENGTH_RST;
            plog_reg         <= pclc_pkg::PLOG_RST;
        end
        else
        begin
            state_reg        <= state_next;
            sample_count_reg <= sample_count_next;
            rd_ctrl_reg      <= rd_ctrl_next;
            if (cfg_wen)
            begin
                unique case (cfg_addr)
                    pclc_pkg::CFG_LINE_LENGTH:
                    begin
                        line_length_reg <= cfg_wdata[pclc_pkg::LEN_W-1:0];
                    end
                    pclc_pkg::CFG_PADDED_LOG2:
                    begin
                        plog_reg <= cfg_wdata[pclc_pkg::PLOG_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        p_reg         <= p_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        t_reg         <= t_next;
        k_reg         <= k_next;
        first_reg     <= first_next;
        pad_reg       <= pad_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= line_wdata;
        end
        line_rdata_reg <= line_mem[line_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (kern_we)
        begin
            kern_mem[ADDR_W'(item.tap_index)] <= item.tap_value;
        end
        kern_rdata_reg <= kern_mem[kern_raddr];
    end

    pclc_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    pclc_mac #(
        .LINE_MAX (LINE_MAX)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (rd_ctrl_reg),
        .x      (line_rdata_reg),
        .h      (kern_rdata_reg),
        .done   (mac_done),
        .result (mac_result)
    );

    assign item.ready            = item_ready;
    assign result.valid          = res_valid;
    assign result.filtered_value = out_value_reg;
    assign result.last_of_line   = out_last_reg;

`ifndef NO_ASSERTIONS
    a_one_side_open: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !result.valid)
        else $error("input and result channel open in the same cycle");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == pclc_pkg::ST_DIVIDE))
        else $error("divider finished outside the divide wait");

    a_mac_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == pclc_pkg::ST_WAIT_MAC))
        else $error("MAC result arrived outside the drain wait");

    a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pclc_pkg::ST_PAD) |-> (CNT_W'(k_reg) >= len_reg))
        else $error("pad write would overwrite a line sample");

    a_line_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_of_line)
            |=> (state_reg == pclc_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after the last result");
`endif

endmodule
